@@ design/shs_pkg.sv @@
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned WIN_DEP = 16;
    localparam int unsigned ADDR_W  = 4;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [7:0][WORD_W-1:0] hash_t;

    localparam hash_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    // Control of the round engine from the sequencer
    typedef struct packed {
        logic start;
        logic clear;
    } core_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PAD  = 4'b0010,
        ST_HASH = 4'b0100,
        ST_OUT  = 4'b1000
    } top_state_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Place a byte in lane k of a big-endian word, lane 0 at the top
    function automatic logic [31:0] byte_lane(input logic [7:0] b, input logic [1:0] k);
        logic [31:0] w;
        begin
            case (k)
                2'd0:    w = {b, 24'h0};
                2'd1:    w = {8'h0, b, 16'h0};
                2'd2:    w = {16'h0, b, 8'h0};
                2'd3:    w = {24'h0, b};
                default: w = 32'h0;
            endcase
            byte_lane = w;
        end
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        begin
            case (r)
                6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
                6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
                6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
                6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
                6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
                6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            round_k = k;
        end
    endfunction

endpackage

`default_nettype wire

@@ design/shs_wmem.sv @@
// ----------------------------------------------------------------------------
// shs_wmem
// Sixteen-word block and schedule memory: one write port, two registered
// read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_wmem
    import shs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WORD_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output logic      [WORD_W-1:0] rdata_a,
    output logic      [WORD_W-1:0] rdata_b
);

    logic [WORD_W-1:0] mem [WIN_DEP];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

@@ design/shs_core.sv @@
// ----------------------------------------------------------------------------
// shs_core
// Round engine: one SHA-256 round a cycle, with the message schedule kept
// in place in the word memory and the chain value in registers.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_core
    import shs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire core_ctl_t         ctl,
    output core_stat_t             stat,
    output logic      [ADDR_W-1:0] raddr_a,
    output logic      [ADDR_W-1:0] raddr_b,
    input  wire logic [WORD_W-1:0] rdata_a,
    input  wire logic [WORD_W-1:0] rdata_b,
    output logic                   we,
    output logic      [ADDR_W-1:0] waddr,
    output logic      [WORD_W-1:0] wdata,
    output hash_t                  hash
);

    localparam logic [6:0] STEP_LAST = 7'd66;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  step_reg, step_next;
    logic [31:0] prev_a_reg;
    logic [31:0] wd1_reg, wd2_reg;
    hash_t       v_reg, v_next;
    hash_t       h_reg, h_next;

    logic [6:0]  round_full;
    logic [5:0]  round;
    logic        in_round;
    logic [31:0] w_cur, t1, t2;

    assign round_full = step_reg - 7'd2;
    assign round      = round_full[5:0];
    assign in_round   = busy_reg && (step_reg >= 7'd2) && (step_reg < STEP_LAST);

    // Port A runs two rounds ahead, port B fetches W[r-7] one round ahead
    assign raddr_a = step_reg[3:0];
    assign raddr_b = step_reg[3:0] + 4'd8;

    always_comb
    begin
        if (round < 6'd16)
        begin
            w_cur = prev_a_reg;
        end
        else
        begin
            w_cur = prev_a_reg + small_sig0(rdata_a) + rdata_b + small_sig1(wd2_reg);
        end
    end

    assign t1 = v_reg[7] + big_sig1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + round_k(round) + w_cur;
    assign t2 = big_sig0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign we    = in_round;
    assign waddr = round[3:0];
    assign wdata = w_cur;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        v_next    = v_reg;
        h_next    = h_reg;
        if (ctl.clear)
        begin
            h_next = INIT_HASH;
        end
        if (ctl.start)
        begin
            busy_next = 1'b1;
            step_next = 7'd0;
            v_next    = h_reg;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 7'd1;
            if (in_round)
            begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
            end
            if (step_reg == STEP_LAST)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_next[i] = h_reg[i] + v_reg[i];
                end
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 7'd0;
            h_reg    <= INIT_HASH;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            h_reg    <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        prev_a_reg <= rdata_a;
        if (in_round)
        begin
            wd1_reg <= w_cur;
            wd2_reg <= wd1_reg;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign hash      = h_reg;

endmodule

`default_nettype wire

@@ design/sha256_stream_hasher.sv @@
// A byte that does not fill a block leaves the hasher ready for the next byte.
// The byte that completes a block holds off requests while the engine runs its
// two fetch steps, 64 rounds, one chain update and one hand-off step.
// End of message pads one word a cycle from the word holding the next free
// byte to word 15 (1 to 16 words), then one or two compressions, the second
// after a further padded block. The digest leaves one word a cycle while the
// sink is ready. Reset loads the initial hash and empties the byte count.
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-stream SHA-256: gathers bytes into a word memory, pads, compresses
// and returns the digest word by word.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher
    import shs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  msg_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    top_state_t  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] count_reg, count_next;
    logic [31:0] asm_reg, asm_next;
    logic [3:0]  pw_reg, pw_next;
    logic        first_reg, first_next;
    logic        extra_reg, extra_next;
    logic        final_reg, final_next;
    logic        pad_go_reg, pad_go_next;
    logic [2:0]  oidx_reg, oidx_next;

    core_ctl_t   ctl;
    core_stat_t  stat;
    hash_t       hash;

    logic [3:0]  c_raddr_a, c_raddr_b, c_waddr;
    logic [31:0] c_wdata, rdata_a, rdata_b;
    logic        c_we;
    logic        m_we;
    logic [3:0]  m_waddr;
    logic [31:0] m_wdata;

    logic        in_acc, out_acc;
    logic [63:0] bit_len;
    logic [31:0] pad_word;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;
    assign bit_len = {count_reg[60:0], 3'b000};

    always_comb
    begin
        if (!extra_reg && pw_reg == 4'd14)
        begin
            pad_word = bit_len[63:32];
        end
        else if (!extra_reg && pw_reg == 4'd15)
        begin
            pad_word = bit_len[31:0];
        end
        else if (first_reg)
        begin
            pad_word = ((fill_reg[1:0] == 2'd0) ? 32'h0 : asm_reg)
                     | byte_lane(PAD_BYTE, fill_reg[1:0]);
        end
        else
        begin
            pad_word = 32'h0;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        count_next  = count_reg;
        asm_next    = asm_reg;
        pw_next     = pw_reg;
        first_next  = first_reg;
        extra_next  = extra_reg;
        final_next  = final_reg;
        pad_go_next = pad_go_reg;
        oidx_next   = oidx_reg;
        ctl         = '0;
        m_we        = 1'b0;
        m_waddr     = fill_reg[5:2];
        m_wdata     = asm_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (byte_present)
                    begin
                        asm_next   = ((fill_reg[1:0] == 2'd0) ? 32'h0 : asm_reg)
                                   | byte_lane(msg_byte, fill_reg[1:0]);
                        fill_next  = fill_reg + 6'd1;
                        count_next = count_reg + 64'd1;
                        m_we       = (fill_reg[1:0] == 2'd3);
                        m_wdata    = asm_next;
                    end
                    if (byte_present && fill_reg == 6'd63)
                    begin
                        ctl.start   = 1'b1;
                        state_next  = ST_HASH;
                        final_next  = 1'b0;
                        pad_go_next = end_of_message;
                        pw_next     = 4'd0;
                        first_next  = 1'b1;
                        extra_next  = 1'b0;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                        pw_next    = fill_next[5:2];
                        first_next = 1'b1;
                        extra_next = (fill_next >= 6'd56);
                    end
                end
            end
            ST_PAD:
            begin
                m_we       = 1'b1;
                m_waddr    = pw_reg;
                m_wdata    = pad_word;
                first_next = 1'b0;
                pw_next    = pw_reg + 4'd1;
                if (pw_reg == 4'd15)
                begin
                    ctl.start   = 1'b1;
                    state_next  = ST_HASH;
                    final_next  = !extra_reg;
                    pad_go_next = extra_reg;
                    extra_next  = 1'b0;
                end
            end
            ST_HASH:
            begin
                if (stat.done)
                begin
                    if (final_reg)
                    begin
                        state_next = ST_OUT;
                        oidx_next  = 3'd0;
                    end
                    else if (pad_go_reg)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        ctl.clear   = 1'b1;
                        state_next  = ST_IDLE;
                        fill_next   = 6'd0;
                        count_next  = 64'd0;
                        final_next  = 1'b0;
                        pad_go_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= 6'd0;
            count_reg  <= 64'd0;
            pw_reg     <= 4'd0;
            first_reg  <= 1'b0;
            extra_reg  <= 1'b0;
            final_reg  <= 1'b0;
            pad_go_reg <= 1'b0;
            oidx_reg   <= 3'd0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            count_reg  <= count_next;
            pw_reg     <= pw_next;
            first_reg  <= first_next;
            extra_reg  <= extra_next;
            final_reg  <= final_next;
            pad_go_reg <= pad_go_next;
            oidx_reg   <= oidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        asm_reg <= asm_next;
    end

    // The engine owns the write port while it runs
    shs_wmem u_wmem (
        .clk     (clk),
        .we      (stat.busy ? c_we : m_we),
        .waddr   (stat.busy ? c_waddr : m_waddr),
        .wdata   (stat.busy ? c_wdata : m_wdata),
        .raddr_a (c_raddr_a),
        .raddr_b (c_raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    shs_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .stat    (stat),
        .raddr_a (c_raddr_a),
        .raddr_b (c_raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .we      (c_we),
        .waddr   (c_waddr),
        .wdata   (c_wdata),
        .hash    (hash)
    );

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign digest_word = hash[oidx_reg];
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == 3'd7);

endmodule

`default_nettype wire

@@ design/shs_checker.sv @@
// ----------------------------------------------------------------------------
// shs_checker
// Port-level checks of the stream hasher's request and digest channels.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] digest_word,
    input wire logic [2:0]  word_index,
    input wire logic        last_word
);

    // Requests are never taken while a digest is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request taken during digest output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_word)
                                    && $stable(word_index))
        else $error("stalled digest word changed");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word |=>
            out_valid && word_index == $past(word_index) + 3'd1)
        else $error("digest words out of order");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last word flag misplaced");

    a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_word |=> in_ready && !out_valid)
        else $error("no return to idle after digest");

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
);

`default_nettype wire

@@ dv/tb_sha256_stream_hasher.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher
// Drives byte messages of directed and random lengths into the stream hasher
// with random gaps and stalls, predicts each digest with a local SHA-256 model
// and checks every digest word, index and last flag in order.
// ----------------------------------------------------------------------------
`default_nettype none

class digest_board;
    logic [31:0] chain[8];
    logic [7:0]  buf_b[64];
    int unsigned fill;
    logic [63:0] nbytes;
    logic [35:0] pending[$];   // {word, index, last}
    int unsigned errors;

    function new();
        errors = 0;
        clear_state();
    endfunction

    function void clear_state();
        chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                  32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        fill = 0;
        nbytes = 64'd0;
    endfunction

    function logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function logic [31:0] kconst(input int r);
        logic [31:0] k[64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[r];
    endfunction

    function void compress();
        logic [31:0] w[64];
        logic [31:0] v[8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {buf_b[4*i], buf_b[4*i+1], buf_b[4*i+2], buf_b[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
        v = chain;
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(r) + w[r];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] += v[i];
    endfunction

    // Note an accepted request and queue the digest words it causes
    function void note_request(input logic [7:0] b, input logic present, input logic eom);
        logic [63:0] bits;
        int unsigned p;
        if (present)
        begin
            buf_b[fill] = b;
            fill++;
            nbytes++;
            if (fill == 64)
            begin
                compress();
                fill = 0;
            end
        end
        if (!eom)
            return;
        bits = nbytes << 3;
        p = fill;
        buf_b[p] = 8'h80;
        p++;
        if (p > 56)
        begin
            while (p < 64) buf_b[p++] = 8'h00;
            compress();
            p = 0;
        end
        while (p < 56) buf_b[p++] = 8'h00;
        for (int i = 0; i < 8; i++)
            buf_b[63-i] = bits[8*i +: 8];
        compress();
        for (int i = 0; i < 8; i++)
            pending.push_back({chain[i], 3'(i), i == 7});
        clear_state();
    endfunction

    function void check_word(input logic [31:0] w, input logic [2:0] idx, input logic lst);
        logic [35:0] e;
        if (pending.size() == 0)
        begin
            $error("unexpected digest word %h", w);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (w !== e[35:4])
        begin
            $error("digest_word expected %h actual %h", e[35:4], w);
            errors++;
        end
        if (idx !== e[3:1])
        begin
            $error("word_index expected %0d actual %0d", e[3:1], idx);
            errors++;
        end
        if (lst !== e[0])
        begin
            $error("last_word expected %0d actual %0d", e[0], lst);
            errors++;
        end
    endfunction
endclass

module tb_sha256_stream_hasher;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  msg_byte = 8'h00;
    logic        byte_present = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    digest_board board = new();
    bit          sending_done = 1'b0;
    bit          hold_sink = 1'b0;

    sha256_stream_hasher dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .msg_byte(msg_byte), .byte_present(byte_present),
        .end_of_message(end_of_message),
        .out_valid(out_valid), .out_ready(out_ready),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // Offer one request and hold it until accepted; valid stays high into a
    // request that follows with no gap
    task automatic send_request(input logic [7:0] b, input logic present, input logic eom);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        msg_byte <= b;
        byte_present <= present;
        end_of_message <= eom;
        do @(posedge clk); while (!in_ready);
        board.note_request(b, present, eom);
        @(negedge clk);
    endtask

    task automatic send_message(input int len, input int mode);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                1: b = 8'h00;
                2: b = 8'hff;
                default: b = 8'($urandom);
            endcase
            // scatter some idle requests through the message
            if ($urandom_range(0, 9) == 0)
                send_request(8'($urandom), 1'b0, 1'b0);
            if (i == len - 1 && $urandom_range(0, 1))
            begin
                send_request(b, 1'b1, 1'b1);
                return;
            end
            send_request(b, 1'b1, 1'b0);
        end
        send_request(8'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // idle request, empty message, then lengths around the padding edges
        send_request(8'hff, 1'b0, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'h61, 1'b1, 1'b1);
        send_message(3, 2);
        send_message(15, 1);
        // hold the sink off on a digest while the next message waits to be fed
        hold_sink = 1'b1;
        send_message(56, 0);
        send_message(2, 0);
        hold_sink = 1'b0;
        send_message(55, 0);
        send_message(63, 0);
        send_message(64, 0);
        repeat (5)
        begin
            int len;
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 130)
                                              : $urandom_range(0, 12);
            send_message(len, 0);
        end
        in_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Sink: random stalls, plus one long hold-off counted in cycles
    initial
    begin
        int g;
        bit held;
        held = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink && !held && out_valid)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            g = gap_len();
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            board.check_word(digest_word, word_index, last_word);

    initial
    begin
        wait (sending_done);
        wait (board.pending.size() == 0);
        repeat (300) @(posedge clk);
        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end
endmodule

`default_nettype wire

@@ filelist.f @@
design/shs_pkg.sv
design/shs_wmem.sv
design/shs_core.sv
design/sha256_stream_hasher.sv
design/shs_checker.sv
dv/tb_sha256_stream_hasher.sv
